// ===== hw/rtl/sul_pkg.sv =====
`default_nettype none

package sul_pkg;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [3:0] {
        PH_LEAD,
        PH_SLASH,
        PH_LINE,
        PH_BLOCK,
        PH_BSTAR,
        PH_BODY,
        PH_ESC,
        PH_HEX1,
        PH_HEX2,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        K_DATA    = 3'd0,
        K_WARN    = 3'd1,
        K_END     = 3'd2,
        K_NOMATCH = 3'd3,
        K_NLERR   = 3'd4
    } kind_t;

    localparam logic [7:0] CH_ESC    = 8'h1b;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // one queue entry: a warning pair carries the escaped byte and expands to two results
    typedef struct packed {
        logic [7:0]  data;
        kind_t       kind;
        logic        last;
        logic        pair;
        logic [31:0] line;
    } entry_t;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = 4'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = 4'(c - 8'h37);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = 4'(c - 8'h57);
        end
        return v;
    endfunction

    // bit 8 marks a known escape
    function automatic logic [8:0] escape_code(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            CH_BSLASH: r = {1'b1, CH_BSLASH};
            CH_QUOTE:  r = {1'b1, CH_QUOTE};
            8'h27:     r = {1'b1, 8'h27};
            8'h61:     r = {1'b1, 8'h07};
            8'h62:     r = {1'b1, 8'h08};
            8'h65:     r = {1'b1, CH_ESC};
            8'h66:     r = {1'b1, 8'h0c};
            8'h6e:     r = {1'b1, CH_NL};
            8'h72:     r = {1'b1, 8'h0d};
            8'h74:     r = {1'b1, 8'h09};
            8'h76:     r = {1'b1, 8'h0b};
            default:   r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sul_fifo.sv =====
`default_nettype none

module sul_fifo
    import sul_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire    clk,
    input  wire    rst_n,
    input  wire    push,
    input  entry_t push_entry,
    output logic   full,
    input  wire    pop,
    output entry_t pop_entry,
    output logic   empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    entry_t          slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sul_front.sv =====
`default_nettype none

module sul_front
    import sul_pkg::*;
#(
    parameter int LINE_COUNT_WIDTH = 32
)
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        accept,
    input  wire  [7:0] in_byte,
    input  wire        start_req,
    output logic       push,
    output entry_t     push_entry
);

    phase_t                      phase_reg;
    phase_t                      phase_next;
    phase_t                      cur_phase;
    logic [3:0]                  high_nibble_reg;
    logic [3:0]                  high_nibble_next;
    logic [LINE_COUNT_WIDTH-1:0] line_count_reg;
    logic                        count_inc;
    logic [31:0]                 line_sat;
    logic                        is_space;
    logic [8:0]                  esc;

    assign cur_phase = start_req ? PH_LEAD : phase_reg;
    assign esc       = escape_code(in_byte);

    always_comb
    begin
        is_space = (in_byte == CH_SPACE) || (in_byte inside {[8'h09:8'h0d]});
    end

    generate
        if (LINE_COUNT_WIDTH > 32)
        begin : g_sat
            assign line_sat = (|line_count_reg[LINE_COUNT_WIDTH-1:32]) ? '1
                            : line_count_reg[31:0];
        end
        else
        begin : g_ext
            assign line_sat = 32'(line_count_reg);
        end
    endgenerate

    // next phase
    always_comb
    begin
        phase_next = cur_phase;
        case (cur_phase)
            PH_LEAD:
            begin
                if (is_space)
                begin
                    phase_next = PH_LEAD;
                end
                else if (in_byte == CH_SLASH)
                begin
                    phase_next = PH_SLASH;
                end
                else if (in_byte == CH_QUOTE)
                begin
                    phase_next = PH_BODY;
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_SLASH:
            begin
                if (in_byte == CH_SLASH)
                begin
                    phase_next = PH_LINE;
                end
                else if (in_byte == CH_STAR)
                begin
                    phase_next = PH_BLOCK;
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_LINE:
            begin
                if (in_byte == CH_NL)
                begin
                    phase_next = PH_LEAD;
                end
            end
            PH_BLOCK, PH_BSTAR:
            begin
                if (in_byte == CH_SLASH && cur_phase == PH_BSTAR)
                begin
                    phase_next = PH_LEAD;
                end
                else if (in_byte == CH_STAR)
                begin
                    phase_next = PH_BSTAR;
                end
                else
                begin
                    phase_next = PH_BLOCK;
                end
            end
            PH_BODY:
            begin
                if (in_byte == CH_QUOTE || in_byte == CH_NL)
                begin
                    phase_next = PH_DONE;
                end
                else if (in_byte == CH_BSLASH)
                begin
                    phase_next = PH_ESC;
                end
            end
            PH_ESC:
            begin
                phase_next = (in_byte == CH_X) ? PH_HEX1 : PH_BODY;
            end
            PH_HEX1:
            begin
                phase_next = PH_HEX2;
            end
            PH_HEX2:
            begin
                phase_next = PH_BODY;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase
    end

    // classification of the byte into a queue entry
    always_comb
    begin
        push             = 1'b0;
        count_inc        = 1'b0;
        high_nibble_next = start_req ? 4'd0 : high_nibble_reg;
        push_entry       = '{data: in_byte, kind: K_DATA, last: 1'b0, pair: 1'b0,
                             line: line_sat};
        case (cur_phase)
            PH_LEAD:
            begin
                if (is_space)
                begin
                    count_inc = (in_byte == CH_NL);
                end
                else if (in_byte != CH_SLASH && in_byte != CH_QUOTE)
                begin
                    push            = 1'b1;
                    push_entry.kind = K_NOMATCH;
                    push_entry.last = 1'b1;
                end
            end
            PH_SLASH:
            begin
                if (in_byte != CH_SLASH && in_byte != CH_STAR)
                begin
                    push            = 1'b1;
                    push_entry.data = CH_SLASH;
                    push_entry.kind = K_NOMATCH;
                    push_entry.last = 1'b1;
                end
            end
            PH_LINE:
            begin
                count_inc = (in_byte == CH_NL);
            end
            PH_BLOCK, PH_BSTAR:
            begin
                count_inc = (in_byte == CH_NL);
            end
            PH_BODY:
            begin
                if (in_byte == CH_QUOTE)
                begin
                    push            = 1'b1;
                    push_entry.data = 8'd0;
                    push_entry.kind = K_END;
                    push_entry.last = 1'b1;
                end
                else if (in_byte == CH_NL)
                begin
                    push            = 1'b1;
                    push_entry.kind = K_NLERR;
                    push_entry.last = 1'b1;
                end
                else if (in_byte != CH_BSLASH)
                begin
                    push = 1'b1;
                end
            end
            PH_ESC:
            begin
                if (in_byte != CH_X)
                begin
                    push = 1'b1;
                    if (esc[8])
                    begin
                        push_entry.data = esc[7:0];
                    end
                    else
                    begin
                        push_entry.kind = K_WARN;
                        push_entry.pair = 1'b1;
                    end
                end
            end
            PH_HEX1:
            begin
                high_nibble_next = hex_value(in_byte);
            end
            PH_HEX2:
            begin
                push             = 1'b1;
                push_entry.data  = {high_nibble_reg, hex_value(in_byte)};
                high_nibble_next = 4'd0;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
        push = push && accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_LEAD;
            high_nibble_reg <= 4'd0;
            line_count_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            high_nibble_reg <= high_nibble_next;
            if (count_inc && line_count_reg != '1)
            begin
                line_count_reg <= line_count_reg + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sul_back.sv =====
`default_nettype none

module sul_back
    import sul_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         empty,
    input  entry_t      pop_entry,
    output logic        pop,
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    logic        valid_reg;
    logic        valid_next;
    logic [7:0]  byte_reg;
    logic [7:0]  byte_next;
    kind_t       kind_reg;
    kind_t       kind_next;
    logic        last_reg;
    logic        last_next;
    logic [31:0] line_reg;
    logic [31:0] line_next;
    logic        pend_reg;
    logic        pend_next;
    logic [7:0]  pend_byte_reg;
    logic [7:0]  pend_byte_next;
    logic        load;

    assign load = !valid_reg || m_tready;

    always_comb
    begin
        pop            = 1'b0;
        valid_next     = valid_reg && !m_tready;
        byte_next      = byte_reg;
        kind_next      = kind_reg;
        last_next      = last_reg;
        line_next      = line_reg;
        pend_next      = pend_reg;
        pend_byte_next = pend_byte_reg;
        if (load)
        begin
            if (pend_reg)
            begin
                // second half of a warning pair
                valid_next = 1'b1;
                byte_next  = pend_byte_reg;
                kind_next  = K_WARN;
                last_next  = 1'b0;
                pend_next  = 1'b0;
            end
            else if (!empty)
            begin
                pop        = 1'b1;
                valid_next = 1'b1;
                kind_next  = pop_entry.kind;
                last_next  = pop_entry.last;
                line_next  = pop_entry.line;
                if (pop_entry.pair)
                begin
                    byte_next      = CH_SLASH;
                    pend_next      = 1'b1;
                    pend_byte_next = pop_entry.data;
                end
                else
                begin
                    byte_next = pop_entry.data;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        kind_reg      <= kind_next;
        last_reg      <= last_next;
        line_reg      <= line_next;
        pend_byte_reg <= pend_byte_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {line_reg, byte_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/string_literal_unescaper_unit.sv =====
// string literal unescaper: source bytes in, decoded literal bytes out
// input channel s_*: one source byte per item, s_tuser set on the byte that
// starts a new scan (clears phase and hex state, keeps the newline count)
// output channel m_*: one decoded byte, warning, end, no-match or error per item;
// m_tuser gives the kind, m_tlast marks the item that ends the scan, and
// m_tdata carries the newline count seen so far next to the byte
// throughput: one source byte per cycle while the queue is not full; an unknown
// escape yields two output items, bytes skipped as space or comment yield none
// path: the classifier writes an item that causes a result into the four-entry
// queue as the item is accepted, and the output register loads it from the queue
// once that register is empty or its item is taken, raising m_tvalid
// s_tready drops only while the queue is full, so the classifier keeps taking
// bytes while the output stalls; a stalled output holds its item unchanged
// reset: scan returns to the leading space phase, newline count cleared,
// queue and output emptied
`default_nettype none

module string_literal_unescaper_unit
    import sul_pkg::*;
#(
    parameter int LINE_COUNT_WIDTH = 32
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] in_byte
    input  wire         s_tuser,   // [0] start_req
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,   // [7:0] out_byte, [39:8] line_number
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast    // is_last
);

    logic   accept;
    logic   push;
    entry_t push_entry;
    logic   full;
    logic   pop;
    entry_t pop_entry;
    logic   empty;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    sul_front #(
        .LINE_COUNT_WIDTH (LINE_COUNT_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (s_tdata),
        .start_req  (s_tuser),
        .push       (push),
        .push_entry (push_entry)
    );

    sul_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (empty)
    );

    sul_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .pop_entry (pop_entry),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
